[rtl/core/length_prefixed_frame_receiver_unit_defines.svh]
// Assertion macros used by the checker of the frame receiver.
`ifndef LENGTH_PREFIXED_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define LENGTH_PREFIXED_FRAME_RECEIVER_UNIT_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent, outside reset.
`define LPFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lpfr assertion failed");

// The same check, also evaluated while reset is asserted.
`define LPFR_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("lpfr assertion failed");

`endif

[rtl/core/lpfr_pkg.sv]
`default_nettype none

package lpfr_pkg;

   localparam int CHUNK_MAX_DEF = 32;
   localparam int LEN_W = 7;
   localparam int CMD_DEPTH = 2;
   localparam int RES_DEPTH = 2;
   localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

   localparam logic [7:0] DELIM_RESET = 8'd47;
   localparam logic REG_DELIMITER = 1'b0;

   typedef struct packed {
      logic             bank;
      logic [LEN_W-1:0] len;
   } cmd_type;

   typedef struct packed {
      logic valid;
      logic bank;
   } release_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
      logic       empty_chunk;
   } result_type;

endpackage

`default_nettype wire

[rtl/core/lpfr_ram.sv]
`default_nettype none

module lpfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/core/lpfr_queue.sv]
`default_nettype none

module lpfr_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire logic [WIDTH-1:0]           push_data,
   input  wire logic                       pop,
   output logic                            out_valid,
   output logic      [WIDTH-1:0]           out_data,
   output logic                            full,
   output logic      [$clog2(DEPTH+1)-1:0] count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign out_valid = (count_ff != '0);
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign count     = count_ff;
   assign out_data  = entry_ff[rd_ptr_ff];
   assign do_pop    = pop & out_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[rtl/core/lpfr_front.sv]
`default_nettype none

module lpfr_front #(
   parameter int CHUNK_MAX = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [7:0]                        delimiter,
   input  wire logic                              req_valid,
   input  wire logic [7:0]                        req_rx_byte,
   output logic                                   req_stall,
   input  wire logic                              cmd_full,
   output logic                                   cmd_push,
   output lpfr_pkg::cmd_type                      cmd_data,
   input  wire lpfr_pkg::release_type             release_info,
   output logic                                   ram_wr_en,
   output logic      [$clog2(2*CHUNK_MAX)-1:0]    ram_wr_addr,
   output logic      [7:0]                        ram_wr_data
);

   import lpfr_pkg::*;

   localparam int CNT_W = $clog2(CHUNK_MAX + 2);
   localparam int RA_W  = $clog2(2 * CHUNK_MAX);

   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       len_ff, len_in;
   logic             wr_bank_ff, wr_bank_in;
   logic [1:0]       busy_ff, busy_in;

   logic             accept;
   logic             is_delim;
   logic             at_end;
   logic             room;
   logic [CNT_W-1:0] slot;
   logic [RA_W:0]    addr_sum;

   assign req_stall = busy_ff[wr_bank_ff] | cmd_full;
   assign accept    = req_valid & ~req_stall;
   assign is_delim  = (req_rx_byte == delimiter);
   assign at_end    = (count_ff != '0) && (9'(count_ff) == (9'(len_ff) + 9'd1));
   assign room      = (count_ff <= CNT_W'(CHUNK_MAX));

   assign slot        = count_ff - 1'b1;
   assign addr_sum    = (RA_W+1)'(slot) + (wr_bank_ff ? (RA_W+1)'(CHUNK_MAX) : '0);
   assign ram_wr_addr = addr_sum[RA_W-1:0];
   assign ram_wr_data = req_rx_byte;
   assign ram_wr_en   = accept & ~is_delim & ~at_end & room & (count_ff != '0);

   assign cmd_push      = accept & is_delim & at_end;
   assign cmd_data.bank = wr_bank_ff;
   assign cmd_data.len  = LEN_W'(len_ff);

   always_comb begin
      count_in   = count_ff;
      len_in     = len_ff;
      wr_bank_in = wr_bank_ff;
      busy_in    = busy_ff;
      if (release_info.valid) begin
         busy_in[release_info.bank] = 1'b0;
      end
      if (accept) begin
         if (is_delim && at_end) begin
            count_in = '0;
            if (len_ff != 8'd0) begin
               busy_in[wr_bank_ff] = 1'b1;
               wr_bank_in          = ~wr_bank_ff;
            end
         end else if (is_delim || at_end) begin
            count_in = '0;
         end else if (room) begin
            if (count_ff == '0) begin
               len_in = req_rx_byte;
            end
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         len_ff     <= '0;
         wr_bank_ff <= 1'b0;
         busy_ff    <= '0;
      end else begin
         count_ff   <= count_in;
         len_ff     <= len_in;
         wr_bank_ff <= wr_bank_in;
         busy_ff    <= busy_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/lpfr_back.sv]
`default_nettype none

module lpfr_back #(
   parameter int CHUNK_MAX = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               cmd_valid,
   input  wire lpfr_pkg::cmd_type                  cmd_data,
   output logic                                    cmd_pop,
   output logic                                    ram_rd_en,
   output logic      [$clog2(2*CHUNK_MAX)-1:0]     ram_rd_addr,
   input  wire logic [7:0]                         ram_rd_data,
   output lpfr_pkg::release_type                   release_info,
   output logic                                    res_push,
   output lpfr_pkg::result_type                    res_data,
   input  wire logic [lpfr_pkg::RES_CNT_W-1:0]     res_count,
   input  wire logic                               res_pop
);

   import lpfr_pkg::*;

   localparam int RA_W = $clog2(2 * CHUNK_MAX);

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   state_type        state_ff;
   logic             bank_ff;
   logic [LEN_W-1:0] len_ff;
   logic [LEN_W-1:0] idx_ff;
   logic             pend_ff;
   logic             pend_last_ff;
   logic             pend_empty_ff;

   logic [RES_CNT_W:0] occupancy;
   logic               space;
   logic               issue;
   logic               rd_bank;
   logic [LEN_W-1:0]   rd_slot;
   logic               rd_last;
   logic               cmd_is_empty;
   logic [RA_W:0]      addr_sum;

   assign occupancy    = (RES_CNT_W+1)'(res_count) + (RES_CNT_W+1)'(pend_ff)
                         - (RES_CNT_W+1)'(res_pop);
   assign space        = (occupancy < (RES_CNT_W+1)'(RES_DEPTH));
   assign cmd_is_empty = (cmd_data.len == '0);

   always_comb begin
      cmd_pop = 1'b0;
      issue   = 1'b0;
      rd_bank = bank_ff;
      rd_slot = idx_ff;
      rd_last = (LEN_W'(idx_ff + 1'b1) == len_ff);
      unique case (state_ff)
         ST_IDLE: begin
            cmd_pop = cmd_valid & space;
            issue   = cmd_pop;
            rd_bank = cmd_data.bank;
            rd_slot = '0;
            rd_last = (cmd_data.len == LEN_W'(1));
         end
         ST_READ: begin
            issue = space;
         end
         default: begin
            issue = 1'b0;
         end
      endcase
   end

   assign ram_rd_en          = issue & ~((state_ff == ST_IDLE) & cmd_is_empty);
   assign addr_sum           = (RA_W+1)'(rd_slot) + (rd_bank ? (RA_W+1)'(CHUNK_MAX) : '0);
   assign ram_rd_addr        = addr_sum[RA_W-1:0];
   assign release_info.valid = ram_rd_en & rd_last;
   assign release_info.bank  = rd_bank;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         pend_ff <= issue;
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd_pop && !cmd_is_empty && !rd_last) begin
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               if (space && rd_last) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         pend_last_ff  <= rd_last | ((state_ff == ST_IDLE) & cmd_is_empty);
         pend_empty_ff <= (state_ff == ST_IDLE) & cmd_is_empty;
      end
      if (cmd_pop) begin
         bank_ff <= cmd_data.bank;
         len_ff  <= cmd_data.len;
         idx_ff  <= LEN_W'(1);
      end else if ((state_ff == ST_READ) && space) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   assign res_push              = pend_ff;
   assign res_data.data_byte    = pend_empty_ff ? 8'd0 : ram_rd_data;
   assign res_data.last_byte    = pend_last_ff;
   assign res_data.empty_chunk  = pend_empty_ff;

endmodule

`default_nettype wire

[rtl/core/length_prefixed_frame_receiver_unit.sv]
// The first result of a good frame passes through the frame queue, the payload memory read and
// the result queue before it is offered.
// Throughput: one received byte per cycle, and one result per cycle while rsp_stall is low;
// the byte input stalls while both payload buffers hold frames still waiting to be read out by
// the result side, or while two completed frames wait in the frame queue.
// Reset is synchronous and active high: counts, queues and buffer ownership clear, the
// delimiter returns to 47, and the payload memory keeps its contents.
`default_nettype none

module length_prefixed_frame_receiver_unit #(
   parameter int CHUNK_MAX = lpfr_pkg::CHUNK_MAX_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic      [7:0]  rsp_data_byte,
   output logic             rsp_last_byte,
   output logic             rsp_empty_chunk,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   import lpfr_pkg::*;

   localparam int RA_W = $clog2(2 * CHUNK_MAX);

   logic [7:0]  delimiter_ff, delimiter_in;
   logic        csr_write;

   logic        cmd_push;
   cmd_type     cmd_push_data;
   logic        cmd_full;
   logic        cmd_valid;
   cmd_type     cmd_out_data;
   logic        cmd_pop;

   release_type release_info;

   logic             ram_wr_en;
   logic [RA_W-1:0]  ram_wr_addr;
   logic [7:0]       ram_wr_data;
   logic             ram_rd_en;
   logic [RA_W-1:0]  ram_rd_addr;
   logic [7:0]       ram_rd_data;

   logic                 res_push;
   result_type           res_push_data;
   result_type           res_out_data;
   logic                 res_full;
   logic [RES_CNT_W-1:0] res_count;
   logic                 res_pop;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_DELIMITER) ? {24'd0, delimiter_ff} : 32'd0;

   always_comb begin
      delimiter_in = delimiter_ff;
      if (csr_write && (csr_paddr[2] == REG_DELIMITER)) begin
         delimiter_in = csr_pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delimiter_ff <= DELIM_RESET;
      end else begin
         delimiter_ff <= delimiter_in;
      end
   end

   lpfr_front #(
      .CHUNK_MAX (CHUNK_MAX)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .delimiter    (delimiter_ff),
      .req_valid    (req_valid),
      .req_rx_byte  (req_rx_byte),
      .req_stall    (req_stall),
      .cmd_full     (cmd_full),
      .cmd_push     (cmd_push),
      .cmd_data     (cmd_push_data),
      .release_info (release_info),
      .ram_wr_en    (ram_wr_en),
      .ram_wr_addr  (ram_wr_addr),
      .ram_wr_data  (ram_wr_data)
   );

   lpfr_queue #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_push_data),
      .pop       (cmd_pop),
      .out_valid (cmd_valid),
      .out_data  (cmd_out_data),
      .full      (cmd_full),
      .count     ()
   );

   lpfr_ram #(
      .WIDTH (8),
      .DEPTH (2 * CHUNK_MAX)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   lpfr_back #(
      .CHUNK_MAX (CHUNK_MAX)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_valid    (cmd_valid),
      .cmd_data     (cmd_out_data),
      .cmd_pop      (cmd_pop),
      .ram_rd_en    (ram_rd_en),
      .ram_rd_addr  (ram_rd_addr),
      .ram_rd_data  (ram_rd_data),
      .release_info (release_info),
      .res_push     (res_push),
      .res_data     (res_push_data),
      .res_count    (res_count),
      .res_pop      (res_pop)
   );

   lpfr_queue #(
      .WIDTH ($bits(result_type)),
      .DEPTH (RES_DEPTH)
   ) u_res_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_push_data),
      .pop       (res_pop),
      .out_valid (rsp_valid),
      .out_data  (res_out_data),
      .full      (res_full),
      .count     (res_count)
   );

   assign res_pop         = rsp_valid & ~rsp_stall & ~(res_full & 1'b0);
   assign rsp_data_byte   = res_out_data.data_byte;
   assign rsp_last_byte   = res_out_data.last_byte;
   assign rsp_empty_chunk = res_out_data.empty_chunk;

endmodule

`default_nettype wire

[rtl/core/lpfr_checker.sv]
`default_nettype none
`include "length_prefixed_frame_receiver_unit_defines.svh"

module lpfr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic [7:0]  req_rx_byte,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [7:0]  rsp_data_byte,
   input wire logic        rsp_last_byte,
   input wire logic        rsp_empty_chunk,
   input wire logic        csr_psel,
   input wire logic        csr_penable,
   input wire logic        csr_pwrite,
   input wire logic [2:0]  csr_paddr,
   input wire logic [31:0] csr_pwdata,
   input wire logic [31:0] csr_prdata,
   input wire logic        csr_pready
);

   `LPFR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_data_byte) && $stable(rsp_last_byte)
      && $stable(rsp_empty_chunk))

   `LPFR_ASSERT_NEXT(a_req_hold, clock, reset, req_valid && req_stall,
      req_valid && $stable(req_rx_byte))

   `LPFR_ASSERT_NEXT_ALWAYS(a_reset_idle, clock, reset, !req_stall && !rsp_valid)

   `LPFR_ASSERT_NEXT(a_csr_readback, clock, reset,
      csr_psel && csr_penable && csr_pwrite && csr_pready && !csr_paddr[2],
      !csr_paddr[2] || (csr_prdata == {24'd0, $past(csr_pwdata[7:0])}))

endmodule

bind length_prefixed_frame_receiver_unit lpfr_checker u_lpfr_checker (.*);

`default_nettype wire

[test/tb_top.sv]
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import lpfr_pkg::*;

   localparam int CHUNK = CHUNK_MAX_DEF;
   localparam int DRAIN_CYCLES = 12;
   localparam int IDLE_LIMIT = 4000;
   localparam int PHASE_ITEMS = 60;
   localparam logic [2:0] DELIM_ADDR = 3'(4 * int'(REG_DELIMITER));

   typedef enum logic [1:0] {
      ROW_FROM_MODEL,
      ROW_NO_RESULT,
      ROW_EMPTY_FRAME
   } row_check_type;

   typedef struct packed {
      logic [7:0]    rx;
      row_check_type check;
   } frame_row_type;

   // Directed frames with the reset delimiter '/'.
   localparam frame_row_type DIRECTED_ROWS [0:22] = '{
      '{8'h00, ROW_NO_RESULT}, '{8'h2F, ROW_EMPTY_FRAME}, '{8'h2F, ROW_NO_RESULT},
      '{8'h01, ROW_NO_RESULT}, '{8'hFF, ROW_NO_RESULT}, '{8'h2F, ROW_FROM_MODEL},
      '{8'h02, ROW_NO_RESULT}, '{8'h00, ROW_NO_RESULT}, '{8'h2F, ROW_NO_RESULT},
      '{8'h01, ROW_NO_RESULT}, '{8'hAA, ROW_NO_RESULT}, '{8'h55, ROW_NO_RESULT},
      '{8'h02, ROW_NO_RESULT}, '{8'h80, ROW_NO_RESULT}, '{8'h7F, ROW_NO_RESULT},
      '{8'h2F, ROW_FROM_MODEL},
      '{8'hFF, ROW_NO_RESULT}, '{8'h11, ROW_NO_RESULT}, '{8'h22, ROW_NO_RESULT},
      '{8'h2F, ROW_NO_RESULT},
      '{8'h01, ROW_NO_RESULT}, '{8'h00, ROW_NO_RESULT}, '{8'h2F, ROW_FROM_MODEL}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_data_byte;
   logic        rsp_last_byte;
   logic        rsp_empty_chunk;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = 3'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   logic [7:0]  delim_q = DELIM_RESET;
   logic [6:0]  count_q = 7'd0;
   logic [7:0]  flen_q = 8'd0;
   logic [7:0]  store_q [CHUNK];
   result_type  pending_payload [$];
   result_type  want;
   int          mismatches = 0;
   int          items_sent = 0;
   int          idle_cycles = 0;
   int          stall_left = 0;
   bit          req_steady = 1'b0;
   bit          rsp_steady = 1'b0;

   length_prefixed_frame_receiver_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data_byte(rsp_data_byte),
      .rsp_last_byte(rsp_last_byte),
      .rsp_empty_chunk(rsp_empty_chunk),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #1 clock = ~clock;

   // Advances the frame state by one received byte and, when keep is set, queues the payload it releases.
   function automatic void deframe_byte(input logic [7:0] b, input bit keep);
      bit is_delim;
      bit at_end;
      result_type r;
      is_delim = (b == delim_q);
      at_end = (count_q != 7'd0) && (int'(count_q) == int'(flen_q) + 1);
      if (is_delim && at_end) begin
         count_q = 7'd0;
         if (flen_q == 8'd0) begin
            r = '{data_byte: 8'h00, last_byte: 1'b1, empty_chunk: 1'b1};
            if (keep) pending_payload.push_back(r);
         end else begin
            for (int k = 0; k < int'(flen_q) && k < CHUNK; k++) begin
               r = '{data_byte: store_q[k], last_byte: (k + 1 == int'(flen_q)),
                     empty_chunk: 1'b0};
               if (keep) pending_payload.push_back(r);
            end
         end
      end else if (at_end || is_delim) begin
         count_q = 7'd0;
      end else if (int'(count_q) <= CHUNK) begin
         if (count_q == 7'd0) begin
            flen_q = b;
         end else if (int'(count_q) - 1 < CHUNK) begin
            store_q[int'(count_q) - 1] = b;
         end
         count_q = count_q + 7'd1;
      end
   endfunction

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [7:0] other_byte();
      logic [7:0] b;
      do begin
         b = 8'($urandom_range(0, 255));
      end while (b == delim_q);
      return b;
   endfunction

   function automatic logic [7:0] pick_length();
      int r;
      logic [7:0] len;
      do begin
         r = $urandom_range(0, 99);
         if (r < 10) len = 8'd0;
         else if (r < 85) len = 8'($urandom_range(1, 8));
         else if (r < 93) len = 8'($urandom_range(9, CHUNK - 1));
         else if (r < 97) len = 8'(CHUNK);
         else len = 8'($urandom_range(CHUNK + 1, 255));
      end while (len == delim_q);
      return len;
   endfunction

   task automatic send_byte(input logic [7:0] value, input bit keep);
      int gap;
      gap = req_steady ? 0 : gap_length();
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_rx_byte = value;
      do @(posedge clock); while (req_stall);
      items_sent++;
      deframe_byte(value, keep);
   endtask

   task automatic send_frame_sequence();
      int kind;
      int plen;
      int cut;
      logic [7:0] len;
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
         repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), 1'b1);
         return;
      end
      len = pick_length();
      send_byte(len, 1'b1);
      plen = (int'(len) > CHUNK) ? $urandom_range(CHUNK + 1, CHUNK + 8) : int'(len);
      cut = (kind < 20 && plen > 0) ? $urandom_range(0, plen - 1) : plen;
      for (int i = 0; i < cut; i++) send_byte(other_byte(), 1'b1);
      if (kind >= 20 && kind < 28) begin
         send_byte(other_byte(), 1'b1);
      end else if (kind < 96) begin
         send_byte(delim_q, 1'b1);
      end
   endtask

   task automatic quiesce();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_payload.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write_delim(input logic [7:0] value);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_penable = 1'b0;
      csr_paddr = DELIM_ADDR;
      csr_pwdata = {24'd0, value};
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      delim_q = value;
      @(negedge clock);
      csr_pwrite = 1'b0;
      csr_penable = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[7:0] !== value) begin
         $display("%0t delimiter readback: expected %h actual %h", $time, value,
                  csr_prdata[7:0]);
         mismatches++;
      end
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
   endtask

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall = 1'b1;
         stall_left--;
      end else begin
         stall_left = rsp_steady ? 0 : gap_length();
         rsp_stall = (stall_left > 0);
         if (stall_left > 0) stall_left--;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_payload.size() == 0) begin
            $display("%0t unexpected transfer: expected none actual %h/%b/%b", $time,
                     rsp_data_byte, rsp_last_byte, rsp_empty_chunk);
            mismatches++;
         end else begin
            want = pending_payload.pop_front();
            if (rsp_data_byte !== want.data_byte) begin
               $display("%0t data_byte: expected %h actual %h", $time, want.data_byte,
                        rsp_data_byte);
               mismatches++;
            end
            if (rsp_last_byte !== want.last_byte) begin
               $display("%0t last_byte: expected %b actual %b", $time, want.last_byte,
                        rsp_last_byte);
               mismatches++;
            end
            if (rsp_empty_chunk !== want.empty_chunk) begin
               $display("%0t empty_chunk: expected %b actual %b", $time, want.empty_chunk,
                        rsp_empty_chunk);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("%0t watchdog expired with %0d results outstanding", $time,
                     pending_payload.size());
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      logic [7:0] phase_delim [5];
      int target;
      phase_delim = '{DELIM_RESET, 8'h00, 8'hFF, 8'($urandom_range(1, 254)), DELIM_RESET};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (DIRECTED_ROWS[i]) begin
         send_byte(DIRECTED_ROWS[i].rx, DIRECTED_ROWS[i].check == ROW_FROM_MODEL);
         if (DIRECTED_ROWS[i].check == ROW_EMPTY_FRAME) begin
            pending_payload.push_back('{data_byte: 8'h00, last_byte: 1'b1,
                                        empty_chunk: 1'b1});
         end
      end

      for (int p = 0; p < 5; p++) begin
         if (p > 0) begin
            quiesce();
            csr_write_delim(phase_delim[p]);
         end
         req_steady = (p == 2);
         rsp_steady = (p == 3);
         target = items_sent + PHASE_ITEMS;
         while (items_sent < target) send_frame_sequence();
      end

      quiesce();
      if (mismatches == 0 && pending_payload.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
